[rtl/core/zrhc_pkg.sv]
// shared types and constants of the zero-run halfword compressor
package zrhc_pkg;

    localparam logic [13:0] MAX_POS = 14'd16383;
    localparam int          QDEPTH  = 2;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_ZERO  = 2'd1;
    localparam logic [1:0] PH_LIT   = 2'd2;

    localparam logic CFG_CHECKED = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    typedef struct packed {
        logic [13:0] offset;
        logic [15:0] data;
        logic        done_res;
        logic        fail;
        logic [14:0] size_bytes;
    } rec_t;

    typedef struct packed {
        rec_t [3:0] recs;
        logic [2:0] cnt;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

[rtl/core/zero_run_halfword_compressor.sv]
// top level of the zero-run halfword compressor
// path: an item's writes go through a queue entry, then the output register
// throughput: one item per cycle while the two-bundle queue has room; writes leave at
// one per cycle while m_ready is high, so the rate is set by the writes per item
// reset: synchronous active-low aresetn clears run state, queue and output valid;
// registers return to plain mode with a limit of 16383
module zero_run_halfword_compressor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_value,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_offset,
    output logic [15:0] m_data,
    output logic        m_done_res,
    output logic        m_fail,
    output logic [14:0] m_size_bytes
);
    import zrhc_pkg::*;

    logic    push;
    logic    pop;
    bundle_t push_bundle;
    bundle_t head;
    qstat_t  qstat;

    zrhc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_last      (s_last),
        .qstat       (qstat),
        .push        (push),
        .push_bundle (push_bundle)
    );

    zrhc_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head        (head),
        .qstat       (qstat)
    );

    zrhc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_offset     (m_offset),
        .m_data       (m_data),
        .m_done_res   (m_done_res),
        .m_fail       (m_fail),
        .m_size_bytes (m_size_bytes)
    );

endmodule

[rtl/core/zrhc_front.sv]
// front end: accepts items, tracks the run state and builds the writes of each item
module zrhc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [13:0]      cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [15:0]      s_value,
    input  logic             s_last,
    input  zrhc_pkg::qstat_t qstat,
    output logic             push,
    output zrhc_pkg::bundle_t push_bundle
);
    import zrhc_pkg::*;

    logic        checked_reg;
    logic [13:0] limit_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] rc_reg, rc_next;
    logic [13:0] wp_reg, wp_next;
    logic [13:0] cs_reg, cs_next;
    logic        sl_reg, sl_next;
    logic        failed_reg, failed_next;
    logic        accept;

    function automatic rec_t mk(input logic [13:0] off, input logic [15:0] d,
                                input logic dn, input logic fl, input logic [14:0] sz);
        rec_t r;
        r.offset     = off;
        r.data       = d;
        r.done_res   = dn;
        r.fail       = fl;
        r.size_bytes = sz;
        return r;
    endfunction

    function automatic logic [13:0] adv(input logic [13:0] p);
        return (p < MAX_POS) ? p + 14'd1 : MAX_POS;
    endfunction

    function automatic logic [15:0] cinc(input logic [15:0] c);
        return (c != 16'hFFFF) ? c + 16'd1 : 16'hFFFF;
    endfunction

    assign s_ready = !qstat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic [2:0]  n;
        logic        ok;
        logic        do_open;
        logic [14:0] size;
        logic [15:0] header;
        rec_t [3:0]  recs;

        phase_next  = phase_reg;
        rc_next     = rc_reg;
        wp_next     = wp_reg;
        cs_next     = cs_reg;
        sl_next     = sl_reg;
        failed_next = failed_reg;
        n           = 3'd0;
        ok          = 1'b1;
        do_open     = 1'b0;
        size        = '0;
        header      = '0;
        recs        = '0;

        if (failed_reg) begin
            if (s_last) begin
                phase_next  = PH_START;
                rc_next     = '0;
                wp_next     = 14'd1;
                cs_next     = '0;
                sl_next     = 1'b0;
                failed_next = 1'b0;
            end
        end else begin
            case (phase_reg)
                PH_ZERO: begin
                    if (s_value == 16'd0) begin
                        rc_next = cinc(rc_next);
                    end else if (checked_reg &&
                                 !(({3'b0, wp_next} + {1'b0, rc_next}) < {3'b0, limit_reg})) begin
                        ok = 1'b0;
                    end else begin
                        recs[n[1:0]] = mk(wp_next, rc_next, 1'b0, 1'b0, '0);
                        n = n + 3'd1;
                        wp_next = adv(wp_next);
                        do_open = 1'b1;
                    end
                end
                PH_LIT: begin
                    if (s_value != 16'd0) begin
                        recs[n[1:0]] = mk(wp_next, s_value, 1'b0, 1'b0, '0);
                        n = n + 3'd1;
                        wp_next = adv(wp_next);
                        rc_next = cinc(rc_next);
                        if (checked_reg && wp_next >= limit_reg) begin
                            ok = 1'b0;
                        end
                    end else begin
                        recs[n[1:0]] = mk(cs_next, rc_next, 1'b0, 1'b0, '0);
                        n = n + 3'd1;
                        phase_next = PH_ZERO;
                        rc_next = 16'd1;
                    end
                end
                default: begin
                    if (s_value == 16'd0) begin
                        sl_next = 1'b0;
                        phase_next = PH_ZERO;
                        rc_next = 16'd1;
                    end else begin
                        sl_next = 1'b1;
                        do_open = 1'b1;
                    end
                end
            endcase

            if (do_open) begin
                if (checked_reg && !(({1'b0, wp_next} + 15'd3) < {1'b0, limit_reg})) begin
                    ok = 1'b0;
                end else begin
                    cs_next = wp_next;
                    wp_next = adv(wp_next);
                    recs[n[1:0]] = mk(wp_next, s_value, 1'b0, 1'b0, '0);
                    n = n + 3'd1;
                    wp_next = adv(wp_next);
                    rc_next = 16'd1;
                    phase_next = PH_LIT;
                end
            end

            if (!ok) begin
                recs[n[1:0]] = mk('0, '0, 1'b1, 1'b1, '0);
                n = n + 3'd1;
                failed_next = 1'b1;
            end else if (s_last) begin
                if (phase_next == PH_ZERO) begin
                    recs[n[1:0]] = mk(wp_next, rc_next, 1'b0, 1'b0, '0);
                    n = n + 3'd1;
                    wp_next = adv(wp_next);
                end else if (phase_next == PH_LIT) begin
                    recs[n[1:0]] = mk(cs_next, rc_next, 1'b0, 1'b0, '0);
                    n = n + 3'd1;
                end
                size   = {wp_next, 1'b0};
                header = checked_reg ? {15'b0, sl_next} : {sl_next, size};
                recs[n[1:0]] = mk('0, header, 1'b1, 1'b0, size);
                n = n + 3'd1;
            end

            if (s_last) begin
                phase_next  = PH_START;
                rc_next     = '0;
                wp_next     = 14'd1;
                cs_next     = '0;
                sl_next     = 1'b0;
                failed_next = 1'b0;
            end
        end

        push_bundle.recs = recs;
        push_bundle.cnt  = n;
        push = accept && (n != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            checked_reg <= 1'b0;
            limit_reg   <= 14'd16383;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CHECKED: checked_reg <= cfg_data[0];
                CFG_LIMIT:   limit_reg   <= cfg_data;
                default:     checked_reg <= checked_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            rc_reg     <= '0;
            wp_reg     <= 14'd1;
            cs_reg     <= '0;
            sl_reg     <= 1'b0;
            failed_reg <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            rc_reg     <= rc_next;
            wp_reg     <= wp_next;
            cs_reg     <= cs_next;
            sl_reg     <= sl_next;
            failed_reg <= failed_next;
        end
    end

endmodule

[rtl/core/zrhc_queue.sv]
// two-entry queue of write bundles between front and back end
module zrhc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  zrhc_pkg::bundle_t push_bundle,
    input  logic              pop,
    output zrhc_pkg::bundle_t head,
    output zrhc_pkg::qstat_t  qstat
);
    import zrhc_pkg::*;

    bundle_t    entry_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'(QDEPTH));
    assign qstat.empty = (count_reg == 2'd0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/zrhc_back.sv]
// back end: issues the writes of each bundle one per cycle, while m_ready allows, through the output register
module zrhc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  zrhc_pkg::bundle_t head,
    input  zrhc_pkg::qstat_t  qstat,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [13:0]       m_offset,
    output logic [15:0]       m_data,
    output logic              m_done_res,
    output logic              m_fail,
    output logic [14:0]       m_size_bytes
);
    import zrhc_pkg::*;

    logic [1:0] idx_reg;
    logic       m_valid_reg;
    rec_t       out_reg;
    rec_t       cur;
    logic       load;
    logic       last_rec;

    assign cur      = head.recs[idx_reg];
    assign load     = !qstat.empty && (!m_valid_reg || m_ready);
    assign last_rec = (({1'b0, idx_reg} + 3'd1) == head.cnt);
    assign pop      = load && last_rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= last_rec ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= cur;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_offset     = out_reg.offset;
    assign m_data       = out_reg.data;
    assign m_done_res   = out_reg.done_res;
    assign m_fail       = out_reg.fail;
    assign m_size_bytes = out_reg.size_bytes;

endmodule

[sim/zero_run_halfword_compressor_checker.sv]
// checker for the zero-run halfword compressor: predicts destination writes and compares them
`timescale 1ns / 100ps

module zero_run_halfword_compressor_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_value,
    input  logic        s_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [13:0] m_offset,
    input  logic [15:0] m_data,
    input  logic        m_done_res,
    input  logic        m_fail,
    input  logic [14:0] m_size_bytes,
    output int          outstanding,
    output int          errors
);
    import zrhc_pkg::*;

    logic        chk_mode;
    logic [13:0] limit_q;
    logic [1:0]  phase;
    logic [15:0] run_count;
    logic [13:0] write_pos;
    logic [13:0] count_slot;
    logic        starts_lit;
    logic        failed;
    rec_t        expected_writes[$];
    int          err_cnt;

    task automatic restart_stream();
        phase      = PH_START;
        run_count  = 16'd0;
        write_pos  = 14'd1;
        count_slot = 14'd0;
        starts_lit = 1'b0;
        failed     = 1'b0;
    endtask

    task automatic emit(input logic [13:0] off, input logic [15:0] data, input logic done,
                        input logic fl, input logic [14:0] size);
        rec_t rec;
        rec.offset     = off;
        rec.data       = data;
        rec.done_res   = done;
        rec.fail       = fl;
        rec.size_bytes = size;
        expected_writes.push_back(rec);
    endtask

    task automatic step_pos();
        if (write_pos < MAX_POS) begin
            write_pos = write_pos + 14'd1;
        end
    endtask

    task automatic open_literal(input logic [15:0] v, output bit ok);
        ok = 1'b1;
        if (chk_mode && !(int'(write_pos) + 3 < int'(limit_q))) begin
            ok = 1'b0;
        end else begin
            count_slot = write_pos;
            step_pos();
            emit(write_pos, v, 1'b0, 1'b0, 15'd0);
            step_pos();
            run_count = 16'd1;
            phase     = PH_LIT;
        end
    endtask

    task automatic compress_halfword(input logic [15:0] v, input logic l);
        bit          ok;
        logic [14:0] size;
        logic [15:0] header;
        ok = 1'b1;
        if (failed) begin
            if (l) begin
                restart_stream();
            end
        end else begin
            case (phase)
                PH_ZERO: begin
                    if (v == 16'd0) begin
                        run_count = (run_count == 16'hFFFF) ? run_count : run_count + 16'd1;
                    end else if (chk_mode
                                 && !(int'(write_pos) + int'(run_count) < int'(limit_q))) begin
                        ok = 1'b0;
                    end else begin
                        emit(write_pos, run_count, 1'b0, 1'b0, 15'd0);
                        step_pos();
                        open_literal(v, ok);
                    end
                end
                PH_LIT: begin
                    if (v != 16'd0) begin
                        emit(write_pos, v, 1'b0, 1'b0, 15'd0);
                        step_pos();
                        run_count = (run_count == 16'hFFFF) ? run_count : run_count + 16'd1;
                        if (chk_mode && write_pos >= limit_q) begin
                            ok = 1'b0;
                        end
                    end else begin
                        emit(count_slot, run_count, 1'b0, 1'b0, 15'd0);
                        phase     = PH_ZERO;
                        run_count = 16'd1;
                    end
                end
                default: begin
                    if (v == 16'd0) begin
                        starts_lit = 1'b0;
                        phase      = PH_ZERO;
                        run_count  = 16'd1;
                    end else begin
                        starts_lit = 1'b1;
                        open_literal(v, ok);
                    end
                end
            endcase

            if (!ok) begin
                emit(14'd0, 16'd0, 1'b1, 1'b1, 15'd0);
                failed = 1'b1;
                if (l) begin
                    restart_stream();
                end
            end else if (l) begin
                // close the open run, then the header word
                if (phase == PH_ZERO) begin
                    emit(write_pos, run_count, 1'b0, 1'b0, 15'd0);
                    step_pos();
                end else if (phase == PH_LIT) begin
                    emit(count_slot, run_count, 1'b0, 1'b0, 15'd0);
                end
                size   = {write_pos, 1'b0};
                header = chk_mode ? {15'd0, starts_lit} : {starts_lit, size};
                emit(14'd0, header, 1'b1, 1'b0, size);
                restart_stream();
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        rec_t want;
        if (!aresetn) begin
            chk_mode = 1'b0;
            limit_q  = 14'd16383;
            restart_stream();
            expected_writes.delete();
            err_cnt = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_CHECKED) begin
                    chk_mode = cfg_data[0];
                end else begin
                    limit_q = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                compress_halfword(s_value, s_last);
            end
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    $error("write with nothing expected: offset %0d data %0h", m_offset, m_data);
                    err_cnt++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("offset", 32'(want.offset), 32'(m_offset));
                    check_field("data", 32'(want.data), 32'(m_data));
                    check_field("done_res", 32'(want.done_res), 32'(m_done_res));
                    check_field("fail", 32'(want.fail), 32'(m_fail));
                    check_field("size_bytes", 32'(want.size_bytes), 32'(m_size_bytes));
                end
            end
        end
        outstanding <= expected_writes.size();
        errors      <= err_cnt;
    end

endmodule

[sim/zero_run_halfword_compressor_test.sv]
// testbench top for the zero-run halfword compressor: stimulus, idling and verdict
`timescale 1ns / 100ps

module zero_run_halfword_compressor_test;
    import zrhc_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [13:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_value;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [13:0] m_offset;
    logic [15:0] m_data;
    logic        m_done_res;
    logic        m_fail;
    logic [14:0] m_size_bytes;
    int          outstanding;
    int          errors;
    int          quiet_cycles;
    bit          src_steady;
    bit          sink_steady;

    zero_run_halfword_compressor dut (.*);

    zero_run_halfword_compressor_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // no item moving on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall before each item, none while sink_steady is set
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(15) == 0) begin
                sink_steady = !sink_steady;
            end
            stall = sink_steady ? 0 : $urandom_range(3);
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_item(input logic [15:0] v, input logic l);
        int gap;
        gap = src_steady ? 0 : $urandom_range(3);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [13:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // alternating zero and literal runs with some noise
    task automatic send_stream(input int len);
        logic [15:0] v;
        bit          in_zero;
        int          run_left;
        in_zero  = 1'($urandom_range(1));
        run_left = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            if (run_left == 0) begin
                in_zero  = !in_zero;
                run_left = $urandom_range(1, 6);
            end
            run_left--;
            if (in_zero) begin
                v = 16'h0000;
            end else begin
                case ($urandom_range(3))
                    0: v = 16'hFFFF;
                    1: v = 16'h0001 << $urandom_range(15);
                    default: v = 16'($urandom_range(1, 65535));
                endcase
            end
            if ($urandom_range(19) == 0) begin
                v = 16'($urandom);
            end
            send_item(v, i == len - 1);
        end
    endtask

    task automatic run_phase(input logic chk, input logic [13:0] lim, input int items);
        int sent;
        int len;
        drain();
        write_reg(CFG_CHECKED, {13'd0, chk});
        write_reg(CFG_LIMIT, lim);
        sent = 0;
        while (sent < items) begin
            len        = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
            src_steady = ($urandom_range(3) == 0);
            send_stream(len);
            sent += len;
            if ($urandom_range(24) == 0) begin
                drain();
            end
        end
        src_steady = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_CHECKED;
        cfg_data    = 14'd0;
        s_valid     = 1'b0;
        s_value     = 16'd0;
        s_last      = 1'b0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain mode: literal start, zero run, literal run, last inside a literal run
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h1234, 1'b1);
        // single zero, single literal, last inside a zero run
        send_item(16'h0000, 1'b1);
        send_item(16'h00FF, 1'b1);
        send_item(16'h5555, 1'b0);
        send_item(16'h0000, 1'b1);

        // checked mode with a tiny limit: literal open fails, rest ignored until last
        drain();
        write_reg(CFG_CHECKED, 14'd1);
        write_reg(CFG_LIMIT, 14'd4);
        send_item(16'hAAAA, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h7FFF, 1'b1);
        // zero run ended by a literal with no room at all
        drain();
        write_reg(CFG_LIMIT, 14'd0);
        send_item(16'h0000, 1'b0);
        send_item(16'h0002, 1'b1);
        // literal run that runs out of room
        drain();
        write_reg(CFG_LIMIT, 14'd8);
        for (int i = 0; i < 8; i++) begin
            send_item(16'h0100 + 16'(i), i == 7);
        end
        // mode switched in the middle of a stream
        drain();
        write_reg(CFG_LIMIT, 14'd16383);
        send_item(16'h0101, 1'b0);
        send_item(16'h0202, 1'b0);
        drain();
        write_reg(CFG_CHECKED, 14'd0);
        send_item(16'h0000, 1'b0);
        send_item(16'h0303, 1'b1);

        run_phase(1'b0, 14'd16383, 50);
        run_phase(1'b1, 14'd16383, 50);
        run_phase(1'b1, 14'($urandom_range(4, 40)), 70);
        run_phase(1'b0, 14'd0, 40);
        run_phase(1'b1, 14'd0, 30);
        run_phase(1'b1, 14'($urandom_range(10, 30)), 70);
        run_phase(1'b0, 14'($urandom), 50);

        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[zero_run_halfword_compressor.f]
rtl/core/zrhc_pkg.sv
rtl/core/zrhc_front.sv
rtl/core/zrhc_queue.sv
rtl/core/zrhc_back.sv
rtl/core/zero_run_halfword_compressor.sv
sim/zero_run_halfword_compressor_checker.sv
sim/zero_run_halfword_compressor_test.sv
